/* rtl/core/msba_pkg.sv */
// ----------------------------------------------------------------------------
// msba_pkg
// Shared types, constants and helpers for the memory map scan bump allocator.
// ----------------------------------------------------------------------------
package msba_pkg;

    // Address space limit: regions are clamped to 2**ADDR_LIMIT_LOG2
    localparam int ADDR_LIMIT_LOG2 = 32;
    // State width: holds the limit itself
    localparam int ADDR_W = ADDR_LIMIT_LOG2 + 1;
    // Result field width
    localparam int OUT_W = 33;
    // Request size / alignment width
    localparam int REQ_W = 33;
    // Width of the align/advance sums, wide enough to never wrap
    localparam int SUM_W = ((ADDR_W > REQ_W) ? ADDR_W : REQ_W) + 2;

    localparam int PAGE_SHIFT = 12;

    localparam logic [ADDR_W-1:0] ADDR_CAP   = {1'b1, {ADDR_LIMIT_LOG2{1'b0}}};
    localparam logic [ADDR_W-1:0] LOW_FLOOR  = ADDR_W'(1) << 20;
    localparam logic [ADDR_W-1:0] PAGE_MASK  = ADDR_W'(12'hFFF);
    localparam logic [REQ_W-1:0]  DEFAULT_ALIGN = REQ_W'(16);

    // Item operation codes
    typedef enum logic [1:0] {
        OP_DESC   = 2'd0,
        OP_FINISH = 2'd1,
        OP_ALLOC  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Firmware memory type codes that count as usable RAM
    localparam logic [31:0] MT_LOADER_CODE   = 32'd1;
    localparam logic [31:0] MT_LOADER_DATA   = 32'd2;
    localparam logic [31:0] MT_BOOT_CODE     = 32'd3;
    localparam logic [31:0] MT_BOOT_DATA     = 32'd4;
    localparam logic [31:0] MT_CONVENTIONAL  = 32'd7;
    localparam logic [31:0] MT_ACPI_RECLAIM  = 32'd9;
    localparam logic [31:0] MT_ACPI_NVS      = 32'd10;

    // Prepared item handed from the input stage to the state stage
    typedef struct packed {
        op_t               op;
        logic              keep;      // descriptor passes all filters
        logic [ADDR_W-1:0] base;      // clamped descriptor start
        logic [ADDR_W-1:0] len;       // clamped descriptor length
        logic [ADDR_W-1:0] stop;      // clamped descriptor end
        logic [REQ_W-1:0]  size;      // allocate size
        logic [REQ_W-1:0]  align_m1;  // effective alignment minus one
    } prep_t;

    function automatic logic type_usable(input logic [31:0] mt);
        logic ok;
        case (mt)
            MT_LOADER_CODE, MT_LOADER_DATA, MT_BOOT_CODE, MT_BOOT_DATA,
            MT_CONVENTIONAL, MT_ACPI_RECLAIM, MT_ACPI_NVS: ok = 1'b1;
            default:                                       ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Fit a state-width address to the result field width
    function automatic logic [OUT_W-1:0] to_out(input logic [ADDR_W-1:0] a);
        logic [63:0] wide;
        wide = 64'(a);
        return wide[OUT_W-1:0];
    endfunction

endpackage

/* rtl/core/msba_if.sv */
// ----------------------------------------------------------------------------
// msba_in_if / msba_out_if
// Valid/ready channels carrying allocator items and allocator results.
// ----------------------------------------------------------------------------
interface msba_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] mem_type;
    logic [63:0] region_base;
    logic [51:0] page_count;
    logic [32:0] alloc_size;
    logic [32:0] alloc_align;

    modport source (
        output valid, op, mem_type, region_base, page_count, alloc_size, alloc_align,
        input  ready
    );
    modport sink (
        input  valid, op, mem_type, region_base, page_count, alloc_size, alloc_align,
        output ready
    );
endinterface

interface msba_out_if;
    logic        valid;
    logic        ready;
    logic        alloc_ok;
    logic [32:0] alloc_addr;
    logic [32:0] next_free;
    logic [32:0] region_end;
    logic [32:0] ram_top;

    modport source (
        output valid, alloc_ok, alloc_addr, next_free, region_end, ram_top,
        input  ready
    );
    modport sink (
        input  valid, alloc_ok, alloc_addr, next_free, region_end, ram_top,
        output ready
    );
endinterface

/* rtl/core/memory_map_scan_bump_allocator.sv */
// ----------------------------------------------------------------------------
// memory_map_scan_bump_allocator
// Memory map scan followed by a bump pointer allocator over the largest region.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the result side is not stalled, and
// returns exactly one result per item, in order, through the input register
// and then the result register. The rate comes from the state update loop: region
// start, region end, free pointer and RAM top are read and rewritten in the
// same cycle by the compare/add/mask logic of the state stage. Descriptor
// items update the tracked largest region and RAM top, a finish item sets the
// region start (at least 1 MiB, 4 KiB aligned) and loads the free pointer,
// and allocate items align and advance the free pointer within the region.
// Every result reports the free pointer, region end and RAM top after the item.
module memory_map_scan_bump_allocator
    import msba_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    msba_in_if.sink       in_ch,
    msba_out_if.source    out_ch
);

    logic  prep_valid;
    prep_t prep;
    logic  core_ready;

    // Input register with descriptor clamp
    msba_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .core_ready (core_ready),
        .prep_valid (prep_valid),
        .prep       (prep)
    );

    // State and result register
    msba_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .prep_valid (prep_valid),
        .prep       (prep),
        .core_ready (core_ready),
        .out_ch     (out_ch)
    );

endmodule

/* rtl/core/msba_front.sv */
// ----------------------------------------------------------------------------
// msba_front
// Input register: filters and clamps descriptors, resolves the alignment.
// ----------------------------------------------------------------------------
module msba_front
    import msba_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    msba_in_if.sink       in_ch,
    input  logic          core_ready,
    output logic          prep_valid,
    output prep_t         prep
);

    logic              valid_reg;
    logic              valid_next;
    prep_t             prep_reg;
    prep_t             prep_next;
    logic              in_xfer;
    logic              above;
    logic [63:0]       span;
    logic [ADDR_W-1:0] base_lo;
    logic [ADDR_W-1:0] room;
    logic              clamp;

    assign in_ch.ready = !valid_reg || core_ready;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    // Descriptor clamp: end saturates at the address cap
    always_comb
    begin
        above   = |in_ch.region_base[63:ADDR_LIMIT_LOG2];
        base_lo = ADDR_W'(in_ch.region_base[ADDR_LIMIT_LOG2-1:0]);
        span    = {in_ch.page_count, {PAGE_SHIFT{1'b0}}};
        room    = ADDR_CAP - base_lo;
        clamp   = span >= 64'(room);

        prep_next.op       = op_t'(in_ch.op);
        prep_next.keep     = type_usable(in_ch.mem_type) && !above
                             && (in_ch.page_count != '0);
        prep_next.base     = base_lo;
        prep_next.len      = clamp ? room : span[ADDR_W-1:0];
        prep_next.stop     = clamp ? ADDR_CAP : base_lo + span[ADDR_W-1:0];
        prep_next.size     = in_ch.alloc_size;
        prep_next.align_m1 = (in_ch.alloc_align == '0) ? DEFAULT_ALIGN - REQ_W'(1)
                                                       : in_ch.alloc_align - REQ_W'(1);
    end

    // Stage occupancy
    always_comb
    begin
        if (in_xfer)
            valid_next = 1'b1;
        else if (core_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            prep_reg <= prep_next;
    end

    assign prep_valid = valid_reg;
    assign prep       = prep_reg;

endmodule

/* rtl/core/msba_core.sv */
// ----------------------------------------------------------------------------
// msba_core
// Allocator state and result register: region tracking, finish, bump allocate.
// ----------------------------------------------------------------------------
module msba_core
    import msba_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          prep_valid,
    input  prep_t         prep,
    output logic          core_ready,
    msba_out_if.source    out_ch
);

    logic              take;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [ADDR_W-1:0] limit_reg, limit_next;
    logic [ADDR_W-1:0] free_reg, free_next;
    logic [ADDR_W-1:0] high_reg, high_next;
    logic              out_valid_reg;
    logic              ok_reg, ok_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    logic [ADDR_W-1:0] cur_len;
    logic [ADDR_W-1:0] raised;
    logic [ADDR_W-1:0] rounded;
    logic [SUM_W-1:0]  am_ext;
    logic [SUM_W-1:0]  aligned;
    logic [SUM_W-1:0]  bumped;
    logic              fits;

    assign core_ready = !out_valid_reg || out_ch.ready;
    assign take       = prep_valid && core_ready;

    // Per-op datapath
    always_comb
    begin
        cur_len = (limit_reg > start_reg) ? limit_reg - start_reg : '0;
        raised  = (start_reg < LOW_FLOOR) ? LOW_FLOOR : start_reg;
        rounded = (raised + PAGE_MASK) & ~PAGE_MASK;
        am_ext  = SUM_W'(prep.align_m1);
        aligned = (SUM_W'(free_reg) + am_ext) & ~am_ext;
        bumped  = aligned + SUM_W'(prep.size);
        fits    = bumped <= SUM_W'(limit_reg);

        start_next = start_reg;
        limit_next = limit_reg;
        free_next  = free_reg;
        high_next  = high_reg;
        ok_next    = 1'b0;
        addr_next  = '0;

        case (prep.op)
            OP_DESC:
            begin
                if (prep.keep)
                begin
                    if (prep.stop > high_reg)
                        high_next = prep.stop;
                    if (prep.len > cur_len)
                    begin
                        start_next = prep.base;
                        limit_next = prep.stop;
                    end
                end
            end
            OP_FINISH:
            begin
                start_next = rounded;
                free_next  = rounded;
            end
            OP_ALLOC:
            begin
                if (fits)
                begin
                    free_next = bumped[ADDR_W-1:0];
                    ok_next   = 1'b1;
                    addr_next = aligned[ADDR_W-1:0];
                end
            end
            default:
            begin
                // unknown op leaves state alone
            end
        endcase
    end

    // State and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            limit_reg     <= '0;
            free_reg      <= '0;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                start_reg <= start_next;
                limit_reg <= limit_next;
                free_reg  <= free_next;
                high_reg  <= high_next;
            end
            if (take)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ok_reg   <= ok_next;
            addr_reg <= addr_next;
        end
    end

    // Snapshot fields follow the state registers, which only move on a take
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.alloc_ok   = ok_reg;
    assign out_ch.alloc_addr = to_out(addr_reg);
    assign out_ch.next_free  = to_out(free_reg);
    assign out_ch.region_end = to_out(limit_reg);
    assign out_ch.ram_top    = to_out(high_reg);

    // A granted block never runs past the region end
    a_grant_in_region: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ok_reg) |-> (free_reg <= limit_reg))
        else $error("granted block passes region end");

    // Failed or non-allocate results carry a zero address
    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ok_reg) |-> (addr_reg == '0))
        else $error("nonzero address without a grant");

    // The chosen region end is never above the highest end seen
    a_limit_below_top: assert property (@(posedge clk) disable iff (!rst_n)
        limit_reg <= high_reg)
        else $error("region end above RAM top");

    // State only moves when an item is taken
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> ($stable(free_reg) && $stable(start_reg) && $stable(limit_reg)))
        else $error("allocator state changed without an item");

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for memory_map_scan_bump_allocator. Memory map scans
// (descriptors, a finish, then allocations) are pushed through the input
// channel with random gaps, and the result channel is stalled at random. A
// scoreboard follows the region, free pointer and RAM top for every accepted
// transfer and compares each result transfer, field by field, in order.
// ----------------------------------------------------------------------------
module tb
    import msba_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam logic [32:0] SIZE_4G      = 33'h1_0000_0000;

    typedef struct {
        op_t         op;
        logic [31:0] mem_type;
        logic [63:0] region_base;
        logic [51:0] page_count;
        logic [32:0] alloc_size;
        logic [32:0] alloc_align;
    } alloc_item_t;

    typedef struct {
        logic        ok;
        logic [32:0] addr;
        logic [32:0] next_free;
        logic [32:0] region_end;
        logic [32:0] ram_top;
    } alloc_result_t;

    // Tracks the allocator state and holds the results still owed by the block
    class alloc_scoreboard;
        logic [63:0]   reg_start;
        logic [63:0]   reg_limit;
        logic [63:0]   free_ptr;
        logic [63:0]   top_end;
        alloc_result_t owed_q[$];
        int unsigned   mismatches;

        function new();
            reg_start  = '0;
            reg_limit  = '0;
            free_ptr   = '0;
            top_end    = '0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        function bit mem_type_usable(logic [31:0] mt);
            return mt inside {MT_LOADER_CODE, MT_LOADER_DATA, MT_BOOT_CODE,
                              MT_BOOT_DATA, MT_CONVENTIONAL, MT_ACPI_RECLAIM,
                              MT_ACPI_NVS};
        endfunction

        // Update the state for one accepted input transfer, queue its result
        function void note_item(alloc_item_t it);
            logic [63:0]   cap;
            logic [63:0]   span;
            logic [63:0]   stop;
            logic [63:0]   cur;
            logic [63:0]   al;
            logic [63:0]   p;
            logic [63:0]   grant;
            logic          ok;
            alloc_result_t r;
            cap   = 64'd1 << ADDR_LIMIT_LOG2;
            ok    = 1'b0;
            grant = '0;
            case (it.op)
                OP_DESC:
                begin
                    span = 64'(it.page_count) << PAGE_SHIFT;
                    if (mem_type_usable(it.mem_type) && it.region_base < cap && span != 0)
                    begin
                        // saturate at the address limit, never wrap
                        stop = (span >= cap - it.region_base) ? cap : it.region_base + span;
                        if (stop > top_end)
                            top_end = stop;
                        cur = (reg_limit > reg_start) ? reg_limit - reg_start : 64'd0;
                        if (stop - it.region_base > cur)
                        begin
                            reg_start = it.region_base;
                            reg_limit = stop;
                        end
                    end
                end
                OP_FINISH:
                begin
                    if (reg_start < 64'(LOW_FLOOR))
                        reg_start = 64'(LOW_FLOOR);
                    reg_start = (reg_start + 64'(PAGE_MASK)) & ~64'(PAGE_MASK);
                    free_ptr  = reg_start;
                end
                OP_ALLOC:
                begin
                    al = (it.alloc_align == '0) ? 64'(DEFAULT_ALIGN) : 64'(it.alloc_align);
                    p  = (free_ptr + al - 64'd1) & ~(al - 64'd1);
                    if (p + 64'(it.alloc_size) <= reg_limit)
                    begin
                        free_ptr = p + 64'(it.alloc_size);
                        ok       = 1'b1;
                        grant    = p;
                    end
                end
                default: ;
            endcase
            r.ok         = ok;
            r.addr       = grant[32:0];
            r.next_free  = free_ptr[32:0];
            r.region_end = reg_limit[32:0];
            r.ram_top    = top_end[32:0];
            owed_q.push_back(r);
        endfunction

        function void flag(string what, logic [32:0] want, logic [32:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
        endfunction

        // Compare one result transfer against the oldest owed result
        function void check_result(alloc_result_t got);
            alloc_result_t want;
            if (owed_q.size() == 0)
            begin
                flag("unexpected result, next_free", '0, got.next_free);
                return;
            end
            want = owed_q.pop_front();
            if (want.ok !== got.ok)
                flag("alloc_ok", 33'(want.ok), 33'(got.ok));
            if (want.addr !== got.addr)
                flag("alloc_addr", want.addr, got.addr);
            if (want.next_free !== got.next_free)
                flag("next_free", want.next_free, got.next_free);
            if (want.region_end !== got.region_end)
                flag("region_end", want.region_end, got.region_end);
            if (want.ram_top !== got.ram_top)
                flag("ram_top", want.ram_top, got.ram_top);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    msba_in_if  in_ch ();
    msba_out_if out_ch ();

    memory_map_scan_bump_allocator DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    alloc_scoreboard sb = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests  = 0;
    int unsigned hold_served    = 0;
    int unsigned items_sent     = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result side ready: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                hold_served++;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        alloc_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.ok         = out_ch.alloc_ok;
            got.addr       = out_ch.alloc_addr;
            got.next_free  = out_ch.next_free;
            got.region_end = out_ch.region_end;
            got.ram_top    = out_ch.ram_top;
            sb.check_result(got);
        end
    end

    function automatic alloc_item_t mk_item(op_t op, logic [31:0] mt, logic [63:0] base,
                                            logic [51:0] pages, logic [32:0] size,
                                            logic [32:0] align);
        alloc_item_t it;
        it.op          = op;
        it.mem_type    = mt;
        it.region_base = base;
        it.page_count  = pages;
        it.alloc_size  = size;
        it.alloc_align = align;
        return it;
    endfunction

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(alloc_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= it.op;
        in_ch.mem_type    <= it.mem_type;
        in_ch.region_base <= it.region_base;
        in_ch.page_count  <= it.page_count;
        in_ch.alloc_size  <= it.alloc_size;
        in_ch.alloc_align <= it.alloc_align;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_item(it);
        items_sent++;
    endtask

    function automatic logic [31:0] pick_ram_mt();
        logic [31:0] mt;
        case ($urandom_range(0, 6))
            0:       mt = MT_LOADER_CODE;
            1:       mt = MT_LOADER_DATA;
            2:       mt = MT_BOOT_CODE;
            3:       mt = MT_BOOT_DATA;
            4:       mt = MT_CONVENTIONAL;
            5:       mt = MT_ACPI_RECLAIM;
            default: mt = MT_ACPI_NVS;
        endcase
        return mt;
    endfunction

    // Mostly plausible regions below 4 GiB, some straddling or out of range
    function automatic alloc_item_t random_desc();
        logic [31:0] mt;
        logic [63:0] base;
        logic [51:0] pages;
        int unsigned pick;
        mt   = ($urandom_range(99) < 90) ? pick_ram_mt() : $urandom;
        pick = $urandom_range(99);
        if (pick < 75)
            base = 64'($urandom) & ~64'hFFF;
        else if (pick < 85)
            base = 64'($urandom);
        else if (pick < 95)
            base = 64'h0000_0000_FFFF_F000 - 64'($urandom_range(0, 32'h00FF_FFFF));
        else
            base = {$urandom, $urandom};
        if ($urandom_range(99) < 95)
            pages = 52'($urandom_range(0, 32'd1 << $urandom_range(0, 20)));
        else
            pages = {20'($urandom), $urandom};
        return mk_item(OP_DESC, mt, base, pages, '0, '0);
    endfunction

    function automatic alloc_item_t random_alloc();
        logic [32:0] size;
        logic [32:0] align;
        int unsigned pick;
        size = 33'($urandom_range(0, 32'd1 << $urandom_range(0, 24)));
        if ($urandom_range(99) < 5)
            size = 33'($urandom_range(0, 32'h7FFF_FFFF));
        pick = $urandom_range(99);
        if (pick < 70)
            align = 33'd1 << $urandom_range(0, 12);
        else if (pick < 80)
            align = '0;
        else if (pick < 90)
            align = 33'd1 << $urandom_range(13, 32);
        else
            align = 33'($urandom);
        return mk_item(OP_ALLOC, '0, '0, '0, size, align);
    endfunction

    // Any op, fields anywhere in their ranges
    function automatic alloc_item_t random_noise();
        logic [32:0] size;
        logic [32:0] align;
        size  = ($urandom_range(99) == 0) ? SIZE_4G : 33'($urandom);
        align = ($urandom_range(99) == 0) ? SIZE_4G : 33'($urandom);
        return mk_item(op_t'($urandom_range(0, 3)), $urandom, {$urandom, $urandom},
                       {20'($urandom), $urandom}, size, align);
    endfunction

    task automatic run_directed();
        // allocations against the reset state
        send_item(mk_item(OP_ALLOC, '0, '0, '0, '0, '0));
        send_item(mk_item(OP_ALLOC, '0, '0, '0, 33'd1, '0));
        // unknown op with most fields at their top, size and alignment at 4 GiB
        send_item(mk_item(OP_NONE, '1, '1, '1, SIZE_4G, SIZE_4G));
        // dropped descriptors: two bad types, empty, at the limit, far above it
        send_item(mk_item(OP_DESC, 32'd5, 64'h10_0000, 52'd16, '0, '0));
        send_item(mk_item(OP_DESC, '1, '0, 52'd256, '0, '0));
        send_item(mk_item(OP_DESC, MT_CONVENTIONAL, 64'h20_0000, '0, '0, '0));
        send_item(mk_item(OP_DESC, MT_CONVENTIONAL, 64'h1_0000_0000, 52'd16, '0, '0));
        send_item(mk_item(OP_DESC, MT_CONVENTIONAL, '1, '1, '0, '0));
        // every usable type; the first one (at address 0) stays the largest
        for (int k = 0; k < 7; k++)
        begin
            logic [31:0] mt;
            case (k)
                0:       mt = MT_LOADER_CODE;
                1:       mt = MT_LOADER_DATA;
                2:       mt = MT_BOOT_CODE;
                3:       mt = MT_BOOT_DATA;
                4:       mt = MT_CONVENTIONAL;
                5:       mt = MT_ACPI_RECLAIM;
                default: mt = MT_ACPI_NVS;
            endcase
            send_item(mk_item(OP_DESC, mt, 64'(k) * 64'h10_0000, 52'(16 * (7 - k)), '0, '0));
        end
        // huge page count near the top saturates at 4 GiB
        send_item(mk_item(OP_DESC, MT_BOOT_DATA, 64'hFFFF_0123, '1, '0, '0));
        // start raised to 1 MiB lands above the region end
        send_item(mk_item(OP_FINISH, '0, '0, '0, '0, '0));
        send_item(mk_item(OP_ALLOC, '0, '0, '0, '0, '0));
        // descriptor after finish replaces the empty current region
        send_item(mk_item(OP_DESC, MT_LOADER_CODE, 64'h20_0123, 52'h200, '0, '0));
        send_item(mk_item(OP_FINISH, '0, '0, '0, '0, '0));
        // odd alignment, 4 GiB alignment, 4 GiB size, default alignment
        send_item(mk_item(OP_ALLOC, '0, '0, '0, 33'h10, 33'd3));
        send_item(mk_item(OP_ALLOC, '0, '0, '0, 33'd100, SIZE_4G));
        send_item(mk_item(OP_ALLOC, '0, '0, '0, SIZE_4G, 33'd1));
        send_item(mk_item(OP_ALLOC, '0, '0, '0, 33'h1000, '0));
        send_item(mk_item(OP_ALLOC, '0, '0, '0, 33'h1F_0000, 33'h1000));
    endtask

    // Mostly scan sequences (descriptors, finish, allocations), some noise
    task automatic random_phase(int unsigned target);
        int unsigned n;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 80)
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_item(random_desc());
                send_item(mk_item(OP_FINISH, '0, '0, '0, '0, '0));
                n = $urandom_range(2, 10);
                repeat (n) send_item(random_alloc());
            end
            else
                send_item(random_noise());
        end
    endtask

    // Stimulus and end of run
    initial
    begin : stimulus
        in_ch.valid       = 1'b0;
        in_ch.op          = OP_NONE;
        in_ch.mem_type    = '0;
        in_ch.region_base = '0;
        in_ch.page_count  = '0;
        in_ch.alloc_size  = '0;
        in_ch.alloc_align = '0;
        rst_n             = 1'b0;
        send_idle_pct     = 10;
        recv_stall_pct    = 69;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        random_phase(250);

        send_idle_pct  = 69;
        recv_stall_pct = 10;
        random_phase(480);

        // no idling; a long receiver hold-off backs the block up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        random_phase(720);

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
